// ----- rtl/uesr_pkg.sv -----
// Package for the USB enumeration recovery supervisor: payload types,
// register indexes, reset values and widths. No dependencies.
package uesr_pkg;

  localparam int unsigned NowWidth      = 32;
  localparam int unsigned ThrWidth      = 16;
  localparam int unsigned AttWidth      = 4;
  localparam int unsigned CfgIdxWidth   = 8;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned TimeWidthDef  = 32;

  localparam logic [ThrWidth-1:0] EnumTimeoutRst = 16'd3000;
  localparam logic [ThrWidth-1:0] MinIntervalRst = 16'd1000;
  localparam logic [ThrWidth-1:0] StableRst      = 16'd10000;
  localparam logic [AttWidth-1:0] MaxAttemptsRst = 4'd3;
  localparam logic [AttWidth-1:0] AttSat         = 4'd15;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegEnumTimeout = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegMinInterval = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegStable      = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegMaxAttempts = 8'd3;

  typedef enum logic [1:0] {
    OP_PROCESS   = 2'd0,
    OP_BUS_RESET = 2'd1,
    OP_RECOVERY  = 2'd2,
    OP_INIT_DONE = 2'd3
  } op_e;

  typedef struct packed {
    logic [ThrWidth-1:0] enum_timeout_ms;
    logic [ThrWidth-1:0] min_interval_ms;
    logic [ThrWidth-1:0] stable_ms;
    logic [AttWidth-1:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [NowWidth-1:0] now;
    logic                configured;
  } in_t;

  typedef struct packed {
    logic                reinit;
    logic                deinit_first;
    logic                gave_up;
    logic [AttWidth-1:0] attempts_used;
    logic                pending;
    logic                enumerating;
  } res_t;

endpackage

// ----- rtl/uesr_if.sv -----
// Valid/ready channel interfaces for the supervisor: event input, result
// output and configuration write. Depends on uesr_pkg.
interface uesr_in_if
  import uesr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [NowWidth-1:0] now;
  logic                configured;

  modport source (output valid, op, now, configured, input ready);
  modport sink (input valid, op, now, configured, output ready);
endinterface

interface uesr_out_if
  import uesr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                reinit;
  logic                deinit_first;
  logic                gave_up;
  logic [AttWidth-1:0] attempts_used;
  logic                pending;
  logic                enumerating;

  modport source (output valid, reinit, deinit_first, gave_up, attempts_used, pending,
                  enumerating, input ready);
  modport sink (input valid, reinit, deinit_first, gave_up, attempts_used, pending,
                enumerating, output ready);
endinterface

interface uesr_cfg_if
  import uesr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/uesr_cfg_regs.sv -----
// Configuration register file of the supervisor.
// Depends on uesr_pkg and uesr_cfg_if.
module uesr_cfg_regs
  import uesr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  uesr_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegEnumTimeout: cfg_d.enum_timeout_ms = cfg_i.data;
        RegMinInterval: cfg_d.min_interval_ms = cfg_i.data;
        RegStable:      cfg_d.stable_ms       = cfg_i.data;
        RegMaxAttempts: cfg_d.max_attempts    = cfg_i.data[AttWidth-1:0];
        default:        cfg_d = cfg_q;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enum_timeout_ms <= EnumTimeoutRst;
      cfg_q.min_interval_ms <= MinIntervalRst;
      cfg_q.stable_ms       <= StableRst;
      cfg_q.max_attempts    <= MaxAttemptsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/uesr_engine.sv -----
// Supervisor state and per-event update logic: timers, attempt count,
// pending request. Depends on uesr_pkg.
module uesr_engine
  import uesr_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,   // commit the update for item_i
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output res_t res_o     // result of item_i against the current state
);

  typedef logic [TIME_WIDTH-1:0] tm_t;

  logic                pend_q, pend_d;
  logic                ena_q, ena_d;
  logic                dev_q, dev_d;
  logic [AttWidth-1:0] att_q, att_d;
  tm_t                 bus_q, bus_d;
  tm_t                 lrt_q, lrt_d;
  tm_t                 cst_q, cst_d;

  tm_t now_w;
  tm_t el_bus, el_lrt, el_cst;
  op_e op;

  assign now_w  = TIME_WIDTH'(item_i.now);
  assign op     = op_e'(item_i.op);
  // wrapping differences
  assign el_bus = now_w - bus_q;
  assign el_lrt = now_w - lrt_q;
  assign el_cst = now_w - cst_q;

  always_comb begin
    pend_d = pend_q;
    ena_d  = ena_q;
    dev_d  = dev_q;
    att_d  = att_q;
    bus_d  = bus_q;
    lrt_d  = lrt_q;
    cst_d  = cst_q;
    res_o  = '0;
    case (op)
      OP_BUS_RESET: begin
        bus_d = now_w;
        ena_d = 1'b1;
      end
      OP_RECOVERY: pend_d = 1'b1;
      OP_INIT_DONE: begin
        dev_d = 1'b1;
        cst_d = '0;
      end
      OP_PROCESS: begin
        if (item_i.configured) begin
          ena_d = 1'b0;
          if (cst_q == '0) begin
            cst_d = now_w;
          end else if (el_cst >= TIME_WIDTH'(cfg_i.stable_ms)) begin
            att_d = '0;
          end
        end else begin
          cst_d = '0;
          if (ena_q && (el_bus >= TIME_WIDTH'(cfg_i.enum_timeout_ms))) begin
            ena_d  = 1'b0;
            pend_d = 1'b1;
          end
        end
        if (pend_d) begin
          if (att_d >= cfg_i.max_attempts) begin
            pend_d        = 1'b0;
            res_o.gave_up = 1'b1;
          end else if (!((lrt_q != '0) &&
                         (el_lrt < TIME_WIDTH'(cfg_i.min_interval_ms)))) begin
            pend_d             = 1'b0;
            ena_d              = 1'b0;
            lrt_d              = now_w;
            att_d              = (att_d == AttSat) ? att_d : att_d + 1'b1;
            res_o.reinit       = 1'b1;
            res_o.deinit_first = dev_q;
            dev_d              = 1'b1;
            cst_d              = '0;
          end
        end
      end
      default: pend_d = pend_q;
    endcase
    res_o.attempts_used = att_d;
    res_o.pending       = pend_d;
    res_o.enumerating   = ena_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      ena_q  <= 1'b0;
      dev_q  <= 1'b0;
      att_q  <= '0;
      bus_q  <= '0;
      lrt_q  <= '0;
      cst_q  <= '0;
    end else if (step_i) begin
      pend_q <= pend_d;
      ena_q  <= ena_d;
      dev_q  <= dev_d;
      att_q  <= att_d;
      bus_q  <= bus_d;
      lrt_q  <= lrt_d;
      cst_q  <= cst_d;
    end
  end

endmodule

// ----- rtl/usb_enum_recovery_supervisor.sv -----
// USB enumeration recovery supervisor, top level.
// Channels: in_i takes event words (op, now, configured); out_o gives one
//   result word per event; cfg_i writes the four threshold registers.
// Pipeline: an accepted event is held in the input register, is
//   evaluated against the supervisor state from there and is captured
//   in the result register when that register is free or being taken.
// Throughput: one event per cycle while out_o is not stalled; state update and
//   result come from one pass of subtract/compare logic between the input and result registers.
// Stall: when out_o is not taken the result register holds, the input
//   register fills and in_i.ready drops; nothing is lost or repeated.
// Reset: all state clears (timers unset, no request pending, count zero),
//   thresholds go to 3000 / 1000 / 10000 ms and 3 attempts.
// Config: cfg_i.ready is always high; write only while the block is idle.
// Timestamps are TIME_WIDTH bits wide; differences wrap.
module usb_enum_recovery_supervisor
  import uesr_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uesr_in_if.sink     in_i,
  uesr_out_if.source  out_o,
  uesr_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  in_t  in_q;
  logic in_vld_q;
  res_t res_d, res_q;
  logic out_vld_q;
  logic adv;      // input register moves into the result register

  uesr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.op         <= in_i.op;
      in_q.now        <= in_i.now;
      in_q.configured <= in_i.configured;
    end
  end

  uesr_engine #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.reinit        = res_q.reinit;
  assign out_o.deinit_first  = res_q.deinit_first;
  assign out_o.gave_up       = res_q.gave_up;
  assign out_o.attempts_used = res_q.attempts_used;
  assign out_o.pending       = res_q.pending;
  assign out_o.enumerating   = res_q.enumerating;

`ifndef SYNTH
  // a served request cannot also be dropped
  a_reinit_not_gave_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.reinit && res_q.gave_up))
    else $error("reinit and gave_up in one result");

  a_deinit_needs_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.deinit_first) |-> res_q.reinit)
    else $error("deinit_first without reinit");

  // a reinit clears the request and disarms the enumeration timer
  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.reinit) |-> (!res_q.pending && !res_q.enumerating))
    else $error("reinit left request pending or timer armed");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("evaluated event did not reach result register");
`endif

endmodule
